// ===== hdl/fpc_pkg.sv =====
`timescale 1ns / 1ps

package fpc_pkg;

    localparam int WORDS_PER_BLOCK = 16;
    localparam int POS_W           = $clog2(WORDS_PER_BLOCK);
    localparam int DICT_DEPTH      = 4;
    localparam int FILL_W          = $clog2(DICT_DEPTH + 1);
    localparam int DIST_W          = $clog2(DICT_DEPTH);

    localparam int WORD_W    = 32;
    localparam int TAG_W     = 4;
    localparam int PWIDTH_W  = 6;
    localparam int OUT_BITS  = TAG_W + WORD_W + PWIDTH_W + DIST_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [TAG_W-1:0] {
        TAG_ZERO       = 4'd0,
        TAG_ONES       = 4'd1,
        TAG_BYTE0      = 4'd2,
        TAG_BYTE3      = 4'd3,
        TAG_HI_ZERO    = 4'd4,
        TAG_LO_ZERO    = 4'd5,
        TAG_FF_BYTE0   = 4'd6,
        TAG_FF_HALF    = 4'd7,
        TAG_REP_HALF   = 4'd8,
        TAG_B31_ZERO   = 4'd9,
        TAG_B20_ZERO   = 4'd10,
        TAG_DICT_FULL  = 4'd11,
        TAG_DICT_3B    = 4'd12,
        TAG_DICT_HI    = 4'd13,
        TAG_DICT_B31   = 4'd14,
        TAG_RAW        = 4'd15
    } tag_t;

    function automatic logic [PWIDTH_W-1:0] tag_width(input tag_t tag);
        logic [PWIDTH_W-1:0] w;
        case (tag)
            TAG_ZERO, TAG_ONES:                      w = 6'd0;
            TAG_BYTE0, TAG_BYTE3, TAG_FF_BYTE0:      w = 6'd8;
            TAG_DICT_FULL:                           w = 6'd2;
            TAG_DICT_3B:                             w = 6'd10;
            TAG_DICT_HI, TAG_DICT_B31:               w = 6'd18;
            TAG_RAW:                                 w = 6'd32;
            default:                                 w = 6'd16;
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/fpc_word_pattern_encoder.sv =====
`timescale 1ns / 1ps

// frequent-pattern word encoder
// input stream: one 32-bit word per transaction on s_tdata; words form blocks of
// fpc_pkg::WORDS_PER_BLOCK, and the last four words of the current block serve
// as a match dictionary that restarts with every block
// output stream: one transaction per input word with the pattern tag, payload,
// payload width and dictionary distance on m_tdata; m_tlast marks the last
// word of a block
// path: each word passes an input register, then the pattern and dictionary
// compares into the output register
// throughput: one word per cycle while m_tready allows; the dictionary shift and
// word counter update in the same cycle a word moves into the output register
// stall: while m_tready is low the output register holds, the input register
// takes one more word, then s_tready drops until the output drains
// reset: both stages empty, block position and dictionary fill count at zero
module fpc_word_pattern_encoder
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fpc_pkg::WORD_W-1:0]         s_tdata,   // data_word
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // pattern_tag [3:0], payload [35:4], payload_width [41:36], dict_distance [43:42]
    output logic [fpc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast    // block_end
);

    localparam int DD = fpc_pkg::DICT_DEPTH;

    logic                              in_valid_reg;
    logic [fpc_pkg::WORD_W-1:0]        in_word_reg;
    logic [fpc_pkg::WORD_W-1:0]        recent_reg [DD];
    logic [fpc_pkg::POS_W-1:0]         pos_reg;
    logic [fpc_pkg::POS_W-1:0]         pos_next;
    logic [fpc_pkg::FILL_W-1:0]        fill_reg;
    logic [fpc_pkg::FILL_W-1:0]        fill_next;

    logic                              out_valid_reg;
    fpc_pkg::tag_t                     out_tag_reg;
    logic [fpc_pkg::WORD_W-1:0]        out_payload_reg;
    logic [fpc_pkg::PWIDTH_W-1:0]      out_width_reg;
    logic [fpc_pkg::DIST_W-1:0]        out_dist_reg;
    logic                              out_last_reg;

    logic                              advance;
    logic                              last;
    logic [7:0]                        b0, b1, b2, b3;

    fpc_pkg::tag_t                     fixed_tag;
    logic [fpc_pkg::PWIDTH_W-1:0]      fixed_width;
    logic                              hit11, hit12, hit18;
    logic [fpc_pkg::DIST_W-1:0]        d11, d12, d18;
    fpc_pkg::tag_t                     tag18;
    fpc_pkg::tag_t                     tag_sel;
    logic [fpc_pkg::DIST_W-1:0]        dist_sel;
    logic [fpc_pkg::WORD_W-1:0]        payload_sel;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign b0 = in_word_reg[7:0];
    assign b1 = in_word_reg[15:8];
    assign b2 = in_word_reg[23:16];
    assign b3 = in_word_reg[31:24];

    assign last = (pos_reg == fpc_pkg::POS_W'(fpc_pkg::WORDS_PER_BLOCK - 1));

    // fixed patterns, ordered by payload width then tag number
    always_comb
    begin
        if (in_word_reg == '0)
            fixed_tag = fpc_pkg::TAG_ZERO;
        else if (in_word_reg == '1)
            fixed_tag = fpc_pkg::TAG_ONES;
        else if (b3 == 8'h00 && b2 == 8'h00 && b1 == 8'h00)
            fixed_tag = fpc_pkg::TAG_BYTE0;
        else if (b2 == 8'h00 && b1 == 8'h00 && b0 == 8'h00)
            fixed_tag = fpc_pkg::TAG_BYTE3;
        else if (b3 == 8'hff && b2 == 8'hff && b1 == 8'hff)
            fixed_tag = fpc_pkg::TAG_FF_BYTE0;
        else if (b3 == 8'h00 && b2 == 8'h00)
            fixed_tag = fpc_pkg::TAG_HI_ZERO;
        else if (b1 == 8'h00 && b0 == 8'h00)
            fixed_tag = fpc_pkg::TAG_LO_ZERO;
        else if (b3 == 8'hff && b2 == 8'hff)
            fixed_tag = fpc_pkg::TAG_FF_HALF;
        else if (b3 == b1 && b2 == b0)
            fixed_tag = fpc_pkg::TAG_REP_HALF;
        else if (b3 == 8'h00 && b1 == 8'h00)
            fixed_tag = fpc_pkg::TAG_B31_ZERO;
        else if (b2 == 8'h00 && b0 == 8'h00)
            fixed_tag = fpc_pkg::TAG_B20_ZERO;
        else
            fixed_tag = fpc_pkg::TAG_RAW;
        fixed_width = fpc_pkg::tag_width(fixed_tag);
    end

    // dictionary compares, nearest entry wins within each width class
    always_comb
    begin
        logic [7:0] o1, o2, o3;
        hit11 = 1'b0;
        hit12 = 1'b0;
        hit18 = 1'b0;
        d11   = '0;
        d12   = '0;
        d18   = '0;
        tag18 = fpc_pkg::TAG_DICT_HI;
        for (int d = DD - 1; d >= 0; d--)
        begin
            o1 = recent_reg[d][15:8];
            o2 = recent_reg[d][23:16];
            o3 = recent_reg[d][31:24];
            if (fill_reg > fpc_pkg::FILL_W'(d))
            begin
                if (in_word_reg == recent_reg[d])
                begin
                    hit11 = 1'b1;
                    d11   = fpc_pkg::DIST_W'(d);
                end
                if (b3 == o3 && b2 == o2 && b1 == o1)
                begin
                    hit12 = 1'b1;
                    d12   = fpc_pkg::DIST_W'(d);
                end
                if (b3 == o3 && (b2 == o2 || b1 == o1))
                begin
                    hit18 = 1'b1;
                    d18   = fpc_pkg::DIST_W'(d);
                    tag18 = (b2 == o2) ? fpc_pkg::TAG_DICT_HI : fpc_pkg::TAG_DICT_B31;
                end
            end
        end
    end

    always_comb
    begin
        tag_sel  = fixed_tag;
        dist_sel = '0;
        if (fixed_width == 6'd0)
            tag_sel = fixed_tag;
        else if (hit11)
        begin
            tag_sel  = fpc_pkg::TAG_DICT_FULL;
            dist_sel = d11;
        end
        else if (fixed_width <= 6'd8)
            tag_sel = fixed_tag;
        else if (hit12)
        begin
            tag_sel  = fpc_pkg::TAG_DICT_3B;
            dist_sel = d12;
        end
        else if (fixed_width <= 6'd16)
            tag_sel = fixed_tag;
        else if (hit18)
        begin
            tag_sel  = tag18;
            dist_sel = d18;
        end
    end

    always_comb
    begin
        case (tag_sel)
            fpc_pkg::TAG_BYTE0, fpc_pkg::TAG_FF_BYTE0:
                payload_sel = {24'd0, b0};
            fpc_pkg::TAG_BYTE3:
                payload_sel = {24'd0, b3};
            fpc_pkg::TAG_HI_ZERO, fpc_pkg::TAG_FF_HALF, fpc_pkg::TAG_REP_HALF:
                payload_sel = {16'd0, b1, b0};
            fpc_pkg::TAG_LO_ZERO:
                payload_sel = {16'd0, b3, b2};
            fpc_pkg::TAG_B31_ZERO:
                payload_sel = {16'd0, b0, b2};
            fpc_pkg::TAG_B20_ZERO:
                payload_sel = {16'd0, b1, b3};
            fpc_pkg::TAG_DICT_FULL:
                payload_sel = {30'd0, dist_sel};
            fpc_pkg::TAG_DICT_3B:
                payload_sel = {22'd0, b0, dist_sel};
            fpc_pkg::TAG_DICT_HI:
                payload_sel = {14'd0, b1, b0, dist_sel};
            fpc_pkg::TAG_DICT_B31:
                payload_sel = {14'd0, b0, b2, dist_sel};
            fpc_pkg::TAG_RAW:
                payload_sel = in_word_reg;
            default:
                payload_sel = '0;
        endcase
    end

    always_comb
    begin
        pos_next  = last ? '0 : pos_reg + 1'b1;
        fill_next = last ? '0 :
                    (fill_reg == fpc_pkg::FILL_W'(DD)) ? fill_reg : fill_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                pos_reg       <= pos_next;
                fill_reg      <= fill_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_word_reg <= s_tdata;
        if (advance)
        begin
            recent_reg[0]   <= in_word_reg;
            for (int d = 1; d < DD; d++)
                recent_reg[d] <= recent_reg[d-1];
            out_tag_reg     <= tag_sel;
            out_payload_reg <= payload_sel;
            out_width_reg   <= fpc_pkg::tag_width(tag_sel);
            out_dist_reg    <= dist_sel;
            out_last_reg    <= last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(fpc_pkg::OUT_TDATA_W - fpc_pkg::OUT_BITS){1'b0}},
                       out_dist_reg, out_width_reg, out_payload_reg, out_tag_reg};

endmodule

// ===== sim/tb_fpc_word_pattern_encoder.sv =====
`timescale 1ns / 1ps

module tb_fpc_word_pattern_encoder;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 200;
    localparam int N_DIRECTED  = 22;

    typedef struct packed {
        fpc_pkg::tag_t tag;
        logic [31:0]   payload;
        logic [5:0]    pwidth;
        logic [1:0]    dref;
        logic          blk_end;
    } enc_result_t;

    typedef struct packed {
        logic        typed;
        enc_result_t res;
    } pending_word_t;

    typedef struct packed {
        logic [31:0] word;
        logic        typed;
        enc_result_t res;
    } stim_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [fpc_pkg::WORD_W-1:0]      s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [fpc_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tlast;

    fpc_word_pattern_encoder dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // encoder mirror state
    logic [31:0]   recent [4];
    int            block_pos;
    enc_result_t   expected_codes [$];
    pending_word_t offered_words [$];
    logic [31:0]   gen_recent [$];

    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_req;
    int          hold_cnt;
    int          errors;
    int          n_in;
    int          n_out;
    int          n_blocks;
    int          cycles;
    logic [15:0] tags_hit;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{32'h0000_0000, 1'b1, '{fpc_pkg::TAG_ZERO,  32'h0000_0000, 6'd0,  2'd0, 1'b0}},
        '{32'hFFFF_FFFF, 1'b1, '{fpc_pkg::TAG_ONES,  32'h0000_0000, 6'd0,  2'd0, 1'b0}},
        '{32'h0000_00AB, 1'b1, '{fpc_pkg::TAG_BYTE0, 32'h0000_00AB, 6'd8,  2'd0, 1'b0}},
        '{32'hCD00_0000, 1'b1, '{fpc_pkg::TAG_BYTE3, 32'h0000_00CD, 6'd8,  2'd0, 1'b0}},
        '{32'h0000_1234, 1'b0, '0},
        '{32'h5678_0000, 1'b0, '0},
        '{32'hFFFF_FF80, 1'b0, '0},
        '{32'hFFFF_1234, 1'b0, '0},
        '{32'h9A3C_9A3C, 1'b0, '0},
        '{32'h0042_0017, 1'b0, '0},
        '{32'h4200_1700, 1'b0, '0},
        '{32'h9A3C_9A3C, 1'b0, '0},   // full match three words back
        '{32'h4200_1799, 1'b0, '0},
        '{32'h4200_ABCD, 1'b0, '0},
        '{32'h42CD_AB11, 1'b0, '0},
        '{32'h1234_5678, 1'b1, '{fpc_pkg::TAG_RAW,   32'h1234_5678, 6'd32, 2'd0, 1'b1}},
        // new block: dictionary restarts, so the repeat stays raw
        '{32'h1234_5678, 1'b0, '0},
        '{32'h1200_1200, 1'b0, '0},   // tie between repeated half and zero bytes
        '{32'hA5A5_C3C3, 1'b0, '0},
        '{32'h0102_0304, 1'b0, '0},
        '{32'h0F0E_0D0C, 1'b0, '0},
        '{32'h1200_1200, 1'b0, '0}    // match at the farthest distance
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [5:0] bits_of_tag(input fpc_pkg::tag_t tag);
        case (tag)
            fpc_pkg::TAG_ZERO:      return 6'd0;
            fpc_pkg::TAG_ONES:      return 6'd0;
            fpc_pkg::TAG_BYTE0:     return 6'd8;
            fpc_pkg::TAG_BYTE3:     return 6'd8;
            fpc_pkg::TAG_FF_BYTE0:  return 6'd8;
            fpc_pkg::TAG_DICT_FULL: return 6'd2;
            fpc_pkg::TAG_DICT_3B:   return 6'd10;
            fpc_pkg::TAG_DICT_HI:   return 6'd18;
            fpc_pkg::TAG_DICT_B31:  return 6'd18;
            fpc_pkg::TAG_RAW:       return 6'd32;
            default:                return 6'd16;
        endcase
    endfunction

    function automatic enc_result_t encode_word(input logic [31:0] v);
        logic [7:0]    b0;
        logic [7:0]    b1;
        logic [7:0]    b2;
        logic [7:0]    b3;
        logic [31:0]   o;
        logic          fits [11];
        fpc_pkg::tag_t best;
        fpc_pkg::tag_t cand;
        logic [1:0]    near;
        int            avail;
        enc_result_t   r;
        b0 = v[7:0];
        b1 = v[15:8];
        b2 = v[23:16];
        b3 = v[31:24];
        fits[fpc_pkg::TAG_ZERO]     = (v == 32'h0);
        fits[fpc_pkg::TAG_ONES]     = (v == 32'hFFFF_FFFF);
        fits[fpc_pkg::TAG_BYTE0]    = (v[31:8] == 24'h0);
        fits[fpc_pkg::TAG_BYTE3]    = (v[23:0] == 24'h0);
        fits[fpc_pkg::TAG_HI_ZERO]  = (v[31:16] == 16'h0);
        fits[fpc_pkg::TAG_LO_ZERO]  = (v[15:0] == 16'h0);
        fits[fpc_pkg::TAG_FF_BYTE0] = (v[31:8] == 24'hFF_FFFF);
        fits[fpc_pkg::TAG_FF_HALF]  = (v[31:16] == 16'hFFFF);
        fits[fpc_pkg::TAG_REP_HALF] = (v[31:16] == v[15:0]);
        fits[fpc_pkg::TAG_B31_ZERO] = (b3 == 8'h0 && b1 == 8'h0);
        fits[fpc_pkg::TAG_B20_ZERO] = (b2 == 8'h0 && b0 == 8'h0);
        best = fpc_pkg::TAG_RAW;
        near = 2'd0;
        for (int i = 0; i < 11; i++)
        begin
            if (fits[i] && bits_of_tag(fpc_pkg::tag_t'(i)) < bits_of_tag(best))
                best = fpc_pkg::tag_t'(i);
        end
        // only words already seen in this block take part
        avail = (block_pos < 4) ? block_pos : 4;
        for (int d = 0; d < avail; d++)
        begin
            o = recent[d];
            cand = fpc_pkg::TAG_RAW;
            if (v == o)
                cand = fpc_pkg::TAG_DICT_FULL;
            else if (v[31:8] == o[31:8])
                cand = fpc_pkg::TAG_DICT_3B;
            else if (v[31:16] == o[31:16])
                cand = fpc_pkg::TAG_DICT_HI;
            else if (b3 == o[31:24] && b1 == o[15:8])
                cand = fpc_pkg::TAG_DICT_B31;
            if (bits_of_tag(cand) < bits_of_tag(best))
            begin
                best = cand;
                near = d[1:0];
            end
        end
        r = '0;
        r.tag = best;
        r.pwidth = bits_of_tag(best);
        case (best)
            fpc_pkg::TAG_BYTE0, fpc_pkg::TAG_FF_BYTE0:  r.payload = {24'h0, b0};
            fpc_pkg::TAG_BYTE3:                         r.payload = {24'h0, b3};
            fpc_pkg::TAG_HI_ZERO, fpc_pkg::TAG_FF_HALF, fpc_pkg::TAG_REP_HALF:
                r.payload = {16'h0, v[15:0]};
            fpc_pkg::TAG_LO_ZERO:                       r.payload = {16'h0, v[31:16]};
            fpc_pkg::TAG_B31_ZERO:                      r.payload = {16'h0, b0, b2};
            fpc_pkg::TAG_B20_ZERO:                      r.payload = {16'h0, b1, b3};
            fpc_pkg::TAG_DICT_FULL:                     r.payload = {30'h0, near};
            fpc_pkg::TAG_DICT_3B:                       r.payload = {22'h0, b0, near};
            fpc_pkg::TAG_DICT_HI:                       r.payload = {14'h0, v[15:0], near};
            fpc_pkg::TAG_DICT_B31:                      r.payload = {14'h0, b0, b2, near};
            fpc_pkg::TAG_RAW:                           r.payload = v;
            default:                                    r.payload = 32'h0;
        endcase
        if (best == fpc_pkg::TAG_DICT_FULL || best == fpc_pkg::TAG_DICT_3B ||
            best == fpc_pkg::TAG_DICT_HI || best == fpc_pkg::TAG_DICT_B31)
            r.dref = near;
        r.blk_end = (block_pos + 1 >= fpc_pkg::WORDS_PER_BLOCK);
        return r;
    endfunction

    // mostly pattern-shaped words and near copies of recent ones, so that
    // the dictionary compares see real hits
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        int          k;
        k = $urandom_range(99);
        if (k < 20)
            w = $urandom;
        else if (k < 28)
            w = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        else if (k < 50)
        begin
            w = $urandom;
            for (int i = 0; i < 4; i++)
            begin
                case ($urandom_range(2))
                    0:       w[8*i +: 8] = 8'h00;
                    1:       w[8*i +: 8] = 8'hFF;
                    default: ;
                endcase
            end
        end
        else if (k < 58)
        begin
            w = $urandom;
            w[31:16] = w[15:0];
        end
        else if (gen_recent.size() == 0)
            w = $urandom;
        else
        begin
            w = gen_recent[$urandom_range(gen_recent.size() - 1)];
            for (int i = 0; i < 4; i++)
            begin
                if ($urandom_range(3) == 0)
                    w[8*i +: 8] = 8'($urandom);
            end
        end
        gen_recent.push_front(w);
        if (gen_recent.size() > 4)
            void'(gen_recent.pop_back());
        return w;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input logic [31:0] w, input pending_word_t info);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        offered_words.insert(offered_words.size(), info);
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(input int count, input int idle, input int stall);
        pending_word_t info;
        info = '0;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (count)
            send_word(pick_word(), info);
    endtask

    always @(posedge clk)
    begin : monitor
        pending_word_t info;
        enc_result_t   pred;
        enc_result_t   want;
        enc_result_t   got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                info = offered_words.pop_front();
                pred = encode_word(s_tdata);
                expected_codes.insert(expected_codes.size(), info.typed ? info.res : pred);
                recent[3] = recent[2];
                recent[2] = recent[1];
                recent[1] = recent[0];
                recent[0] = s_tdata;
                if (pred.blk_end)
                begin
                    block_pos = 0;
                    n_blocks++;
                end
                else
                    block_pos++;
                n_in++;
            end
            if (m_tvalid && m_tready)
            begin
                got.tag     = fpc_pkg::tag_t'(m_tdata[3:0]);
                got.payload = m_tdata[35:4];
                got.pwidth  = m_tdata[41:36];
                got.dref    = m_tdata[43:42];
                got.blk_end = m_tlast;
                n_out++;
                if (expected_codes.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected tag %0d payload %h width %0d dist %0d last %b",
                             $time, got.tag, got.payload, got.pwidth, got.dref, got.blk_end);
                end
                else
                begin
                    want = expected_codes.pop_front();
                    tags_hit[want.tag] = 1'b1;
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: expected tag %0d payload %h width %0d dist %0d last %b",
                                 $time, want.tag, want.payload, want.pwidth, want.dref,
                                 want.blk_end);
                        $display("%0t: actual   tag %0d payload %h width %0d dist %0d last %b",
                                 $time, got.tag, got.payload, got.pwidth, got.dref,
                                 got.blk_end);
                    end
                end
            end
        end
    end

    // sink side, with a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                hold_cnt++;
                if (hold_cnt >= HOLD_CYCLES)
                begin
                    hold_cnt = 0;
                    hold_req = 1'b0;
                end
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_codes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        pending_word_t info;
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        hold_cnt       = 0;
        errors         = 0;
        n_in           = 0;
        n_out          = 0;
        n_blocks       = 0;
        cycles         = 0;
        tags_hit       = '0;
        block_pos      = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            info.typed = directed_rows[i].typed;
            info.res   = directed_rows[i].res;
            send_word(directed_rows[i].word, info);
        end

        send_random(180, 0, 0);
        send_random(180, 87, 0);
        send_random(180, 0, 87);
        send_random(180, 20, 20);

        // output held off long while words keep coming, so the input stalls
        hold_req = 1'b1;
        send_random(100, 0, 0);

        // hold back until the pipeline has drained
        s_tvalid <= 1'b0;
        while (expected_codes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);

        send_random(80, 20, 20);

        s_tvalid <= 1'b0;
        while (expected_codes.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("covered %0d words (%0d full blocks) with %0d results, %0d of 16 tags seen,",
                 n_in, n_blocks, n_out, $countones(tags_hit));
        $display("under source gaps, sink stalls, a long sink hold-off and a drain pause");
        if (errors == 0 && expected_codes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
